// ===== sv/disjoint_mask_packing_dp_macros.svh =====
// assertion macros for the disjoint mask packing block
`ifndef DISJOINT_MASK_PACKING_DP_MACROS_SVH
`define DISJOINT_MASK_PACKING_DP_MACROS_SVH

// general property, sampled on clk, off during reset
`define DMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define DMP_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== sv/dmp_pkg.sv =====
// shared types and constants for the disjoint mask packing block
package dmp_pkg;

  localparam int MAX_POS_DEFAULT = 10;

  localparam int POS_W  = 4;
  localparam int MODE_W = 2;
  localparam int MASK_W = 10;
  localparam int CNT_W  = 8;

  localparam logic [POS_W-1:0] POS_MIN   = 4'd2;
  localparam logic [POS_W-1:0] POS_RESET = 4'd10;
  localparam logic [CNT_W-1:0] CNT_MAX   = 8'd255;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_POSITIONS = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic init;
    logic load_mask;
    logic swap;
    logic rd;
    logic col_step;
    logic wr;
    logic row_inc;
    logic chk;
    logic out_load;
  } dmp_cmd_t;

  typedef struct packed {
    logic mask_ok;
    logic col_last;
    logic row_last;
    logic out_free;
  } dmp_sts_t;

endpackage

// ===== sv/dmp_ram.sv =====
// generic simple dual-port ram with registered read
module dmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/dmp_ctrl.sv =====
// sequencer for mask sweeps, bitmap swap and feasibility scan
module dmp_ctrl import dmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_stall,
  input  dmp_sts_t          sts,
  output dmp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ADD_RD,
    S_ADD_COL,
    S_ADD_WR,
    S_CHK_RD,
    S_CHK_EV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_START: begin
              state_nxt = S_INIT;
            end
            MODE_ADD: begin
              if (sts.mask_ok) begin
                cmd.load_mask = 1'b1;
                state_nxt     = S_ADD_RD;
              end
            end
            MODE_CLOSE: begin
              cmd.swap  = 1'b1;
              state_nxt = S_CHK_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_ADD_COL;
      end
      S_ADD_COL: begin
        cmd.col_step = 1'b1;
        if (sts.col_last) begin
          state_nxt = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        cmd.wr      = 1'b1;
        cmd.row_inc = 1'b1;
        state_nxt   = sts.row_last ? S_IDLE : S_ADD_RD;
      end
      S_CHK_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK_EV;
      end
      S_CHK_EV: begin
        cmd.chk     = 1'b1;
        cmd.row_inc = 1'b1;
        state_nxt   = sts.row_last ? S_DONE : S_CHK_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ===== sv/dmp_datapath.sv =====
// bitmap banks, sweep counters, item counter and result register
module dmp_datapath import dmp_pkg::*; #(
  parameter int MAX_POSITIONS = MAX_POS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dmp_cmd_t          cmd,
  output dmp_sts_t          sts,
  input  logic [POS_W-1:0]  positions_in_use,
  input  logic [MASK_W-1:0] in_placement_mask,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_feasible,
  output logic [CNT_W-1:0]  out_items_done
);

  localparam int COL_W = MAX_POSITIONS / 2;
  localparam int ROW_W = MAX_POSITIONS - COL_W;
  localparam int COLS  = 1 << COL_W;
  localparam int ROWS  = 1 << ROW_W;

  logic [POS_W-1:0]         pos_eff;
  logic [MAX_POSITIONS-1:0] mask_r, mask_nxt;
  logic [ROW_W-1:0]         mask_hi, tgt_row;
  logic [COL_W-1:0]         mask_lo;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [COLS-1:0]          acc_r, acc_nxt;
  logic                     sel_r, sel_nxt;
  logic [ROWS-1:0]          vld_a_r, vld_a_nxt, vld_b_r, vld_b_nxt;
  logic                     rv_r, rv_nxt, nv_r, nv_nxt;
  logic                     any_r, any_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     feas_r, feas_nxt;
  logic [CNT_W-1:0]         items_r, items_nxt;

  logic [COLS-1:0]          rd_a, rd_b, reach_row, next_row, reach_eff, merged;
  logic [COLS-1:0]          colgate;
  logic                     rowgate, hit;
  logic                     we_a, we_b;
  logic [ROW_W-1:0]         raddr_a, raddr_b, waddr_a;
  logic [COLS-1:0]          wdata_a;

  // clamp the position count to the supported range
  always_comb begin
    if (positions_in_use < POS_MIN) begin
      pos_eff = POS_MIN;
    end else if (positions_in_use > POS_W'(MAX_POSITIONS)) begin
      pos_eff = POS_W'(MAX_POSITIONS);
    end else begin
      pos_eff = positions_in_use;
    end
  end

  assign mask_hi = mask_r[MAX_POSITIONS-1:COL_W];
  assign mask_lo = mask_r[COL_W-1:0];
  assign tgt_row = row_r | mask_hi;

  // entry {row, col} lies below 2^m
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      colgate[c] = ((MAX_POSITIONS'(c) >> pos_eff) == '0);
    end
  end
  assign rowgate = (({row_r, {COL_W{1'b0}}} >> pos_eff) == '0);

  assign reach_row = sel_r ? rd_b : rd_a;
  assign next_row  = sel_r ? rd_a : rd_b;
  assign reach_eff = rv_r ? reach_row : '0;
  assign merged    = (nv_r ? next_row : '0) | acc_r;

  assign hit = reach_eff[col_r] && rowgate && colgate[col_r]
               && ((col_r & mask_lo) == '0) && ((row_r & mask_hi) == '0);

  always_comb begin
    mask_nxt      = cmd.load_mask ? MAX_POSITIONS'(in_placement_mask) : mask_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    acc_nxt       = acc_r;
    sel_nxt       = sel_r;
    vld_a_nxt     = vld_a_r;
    vld_b_nxt     = vld_b_r;
    rv_nxt        = rv_r;
    nv_nxt        = nv_r;
    any_nxt       = any_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    feas_nxt      = feas_r;
    items_nxt     = items_r;

    if (cmd.load_mask || cmd.swap) begin
      row_nxt = '0;
    end else if (cmd.row_inc) begin
      row_nxt = row_r + 1'b1;
    end

    if (cmd.rd) begin
      col_nxt = '0;
      acc_nxt = '0;
      rv_nxt  = sel_r ? vld_b_r[row_r] : vld_a_r[row_r];
      nv_nxt  = sel_r ? vld_a_r[tgt_row] : vld_b_r[tgt_row];
    end else if (cmd.col_step) begin
      col_nxt = col_r + 1'b1;
      if (hit) begin
        acc_nxt[col_r | mask_lo] = 1'b1;
      end
    end

    if (cmd.init) begin
      sel_nxt      = 1'b0;
      vld_a_nxt    = '0;
      vld_a_nxt[0] = 1'b1;
      vld_b_nxt    = '0;
      cnt_nxt      = '0;
      any_nxt      = 1'b0;
    end else if (cmd.swap) begin
      // old reachable bank becomes the empty next bank
      sel_nxt = ~sel_r;
      if (sel_r) begin
        vld_b_nxt = '0;
      end else begin
        vld_a_nxt = '0;
      end
      if (cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      any_nxt = 1'b0;
    end else if (cmd.wr) begin
      if (sel_r) begin
        vld_a_nxt[tgt_row] = 1'b1;
      end else begin
        vld_b_nxt[tgt_row] = 1'b1;
      end
    end else if (cmd.chk) begin
      any_nxt = any_r | (rowgate & (|(reach_eff & colgate)));
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      feas_nxt      = any_r;
      items_nxt     = cnt_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      vld_a_r     <= '0;
      vld_b_r     <= '0;
      cnt_r       <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      rv_r        <= 1'b0;
      nv_r        <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      vld_a_r     <= vld_a_nxt;
      vld_b_r     <= vld_b_nxt;
      cnt_r       <= cnt_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      rv_r        <= rv_nxt;
      nv_r        <= nv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    acc_r   <= acc_nxt;
    feas_r  <= feas_nxt;
    items_r <= items_nxt;
  end

  // bank ports: reachable side reads the swept row, next side the target row
  assign raddr_a = sel_r ? tgt_row : row_r;
  assign raddr_b = sel_r ? row_r : tgt_row;
  assign we_a    = cmd.init | (cmd.wr & sel_r);
  assign we_b    = cmd.wr & ~sel_r;
  assign waddr_a = cmd.init ? '0 : tgt_row;
  assign wdata_a = cmd.init ? COLS'(1) : merged;

  dmp_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_bank_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .re    (cmd.rd),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  dmp_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_bank_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (tgt_row),
    .wdata (merged),
    .re    (cmd.rd),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  assign sts.mask_ok  = ((in_placement_mask >> pos_eff) == '0);
  assign sts.col_last = &col_r;
  assign sts.row_last = &row_r;
  assign sts.out_free = ~out_valid_r | ~out_stall;

  assign out_valid      = out_valid_r;
  assign out_feasible   = feas_r;
  assign out_items_done = items_r;

endmodule

// ===== sv/disjoint_mask_packing_dp.sv =====
// top level of the disjoint mask packing checker
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------
//   in_      | in_valid / in_stall    | in_mode, in_placement_mask
//   out_     | out_valid / out_stall  | out_feasible, out_items_done
//   apb      | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// bitmaps are held as rows of 2^(MAX_POSITIONS/2) bits in two ram banks with
// per-row valid bits; an add with an in-range mask sweeps every row: read,
// step through each column, write back; a close swaps the banks, reads and
// checks every row, then loads the result; a start reseeds the empty set
// after reset an init state seeds the empty set before the first transfer
// a waiting result stalls only the final load of the next close
module disjoint_mask_packing_dp import dmp_pkg::*; #(
  parameter int MAX_POSITIONS = MAX_POS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [MASK_W-1:0]     in_placement_mask,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_feasible,
  output logic [CNT_W-1:0]      out_items_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  `include "disjoint_mask_packing_dp_macros.svh"

  logic [POS_W-1:0] positions_r, positions_nxt;
  logic             reg_hit;
  logic             in_acc;
  dmp_cmd_t         cmd;
  dmp_sts_t         sts;

  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_POSITIONS);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(positions_r) : '0;

  always_comb begin
    positions_nxt = positions_r;
    if (psel && penable && pwrite && reg_hit) begin
      positions_nxt = pwdata[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      positions_r <= POS_RESET;
    end else begin
      positions_r <= positions_nxt;
    end
  end

  dmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmp_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .positions_in_use  (positions_r),
    .in_placement_mask (in_placement_mask),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_feasible      (out_feasible),
    .out_items_done    (out_items_done)
  );

  assign in_acc = in_valid & ~in_stall;

  `DMP_ASSERT_NEXT(a_close_busy, in_acc && (in_mode == MODE_CLOSE), in_stall, "close not busy")
  `DMP_ASSERT(a_start_two, (in_acc && (in_mode == MODE_START)) |-> ##2 !in_stall, "start slow")
  `DMP_ASSERT(a_out_count, $rose(out_valid) |-> (out_items_done != '0), "result with no item")
  `DMP_ASSERT(a_out_busy, $rose(out_valid) |-> $past(in_stall), "result while idle")

endmodule
